// ===== hdl/u8u16_pkg.sv =====
// Shared types and constants of the UTF-8 to UTF-16 transcoder.
package u8u16_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [15:0] UNIT_REPL      = 16'hFFFD;
    localparam logic [15:0] UNIT_NUL       = 16'h0000;
    localparam logic [15:0] SURR_HIGH_BASE = 16'hD800;
    localparam logic [15:0] SURR_LOW_BASE  = 16'hDC00;
    localparam logic [20:0] POINT_PLANE1   = 21'h010000;
    localparam logic [20:0] POINT_MIN3     = 21'h000800;
    localparam logic [20:0] POINT_SURR_LO  = 21'h00D800;
    localparam logic [20:0] POINT_SURR_END = 21'h00E000;
    localparam logic [20:0] POINT_MAX      = 21'h10FFFF;

    // continuation counts announced by a lead byte
    localparam logic [1:0] SEQ_NONE  = 2'd0;
    localparam logic [1:0] SEQ_TWO   = 2'd1;
    localparam logic [1:0] SEQ_THREE = 2'd2;
    localparam logic [1:0] SEQ_FOUR  = 2'd3;

    // one queued request: one or two code units produced by one input byte
    typedef struct packed {
        logic [15:0] unit0;
        logic [15:0] unit1;
        logic        pair;
    } unit_req_t;

endpackage

// ===== hdl/utf8_to_utf16_transcoder.sv =====
// Top level of the UTF-8 to UTF-16 transcoder.
//
// Feed one UTF-8 byte per request on in_byte; the block returns UTF-16 code units on
// code_unit, with last_of_run marking the final unit caused by a byte. It accepts one
// byte every cycle while the output side keeps up: the front end decodes each byte
// combinationally and pushes a request into a short queue, and the back end drains it
// through one output register, one code unit per cycle. A four-byte sequence yields a
// surrogate pair, whose two units leave the output register one after the other; a
// NUL that ends a pending sequence yields 0xFFFD then 0x0000. A byte's first unit is
// registered in a queue slot and then in the output register. Malformed input (bad or
// overlong lead, overlong form, surrogate or out-of-range code point, bad continuation)
// gives 0xFFFD. The cfg port writes swap_reg (cfg_data); set it to 1 for big-endian
// unit order. Write it only while the block is idle; cfg_ready is always high.
module utf8_to_utf16_transcoder
    import u8u16_pkg::*;
#(
    parameter int QUEUE_SLOTS = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] code_unit,
    output logic        last_of_run
);

    logic      swap_reg;
    logic      swap_next;

    logic      push_valid;
    logic      push_ready;
    unit_req_t push_req;
    logic      pop_valid;
    logic      pop_ready;
    unit_req_t pop_req;

    // configuration: take every write request immediately
    assign cfg_ready = 1'b1;
    assign swap_next = cfg_valid ? cfg_data : swap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swap_reg <= 1'b0;
        end
        else
        begin
            swap_reg <= swap_next;
        end
    end

    // decode bytes and hold partial code points
    u8u16_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_req   (push_req)
    );

    // decouple decode from output stalls
    u8u16_queue #(
        .DEPTH (QUEUE_SLOTS)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_req   (push_req),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_req    (pop_req)
    );

    // emit units, sending the two units of a pair one after the other
    u8u16_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .swap        (swap_reg),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_req     (pop_req),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .code_unit   (code_unit),
        .last_of_run (last_of_run)
    );

endmodule

// ===== hdl/u8u16_front.sv =====
// Front end: accepts UTF-8 bytes, tracks the pending sequence, builds unit requests.
module u8u16_front
    import u8u16_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      in_byte,
    output logic            push_valid,
    input  logic            push_ready,
    output unit_req_t       push_req
);

    logic [20:0] partial_reg, partial_next;
    logic [1:0]  left_reg, left_next;
    logic [1:0]  len_reg, len_next;

    logic        fire;
    logic [20:0] acc;
    logic [20:0] offset;
    logic        bad_point;

    assign in_ready = push_ready;
    assign fire     = in_valid && push_ready;

    assign acc    = {partial_reg[14:0], in_byte[5:0]};
    assign offset = acc - POINT_PLANE1;

    assign bad_point = ((len_reg == SEQ_FOUR) && (acc < POINT_PLANE1))
                    || ((len_reg == SEQ_THREE) && (acc < POINT_MIN3))
                    || ((acc >= POINT_SURR_LO) && (acc < POINT_SURR_END))
                    || (acc > POINT_MAX);

    always_comb
    begin
        partial_next = partial_reg;
        left_next    = left_reg;
        len_next     = len_reg;
        push_valid   = 1'b0;
        push_req     = '{unit0: UNIT_REPL, unit1: UNIT_NUL, pair: 1'b0};
        if (fire)
        begin
            if (left_reg != SEQ_NONE)
            begin
                if (in_byte[7:6] != 2'b10)
                begin
                    // drop the sequence; NUL still terminates
                    partial_next = '0;
                    left_next    = SEQ_NONE;
                    len_next     = SEQ_NONE;
                    push_valid   = 1'b1;
                    push_req.pair = (in_byte == 8'h00);
                end
                else if (left_reg == SEQ_TWO)
                begin
                    partial_next = '0;
                    left_next    = SEQ_NONE;
                    len_next     = SEQ_NONE;
                    push_valid   = 1'b1;
                    if (bad_point)
                    begin
                        push_req.unit0 = UNIT_REPL;
                    end
                    else if (acc < POINT_PLANE1)
                    begin
                        push_req.unit0 = acc[15:0];
                    end
                    else
                    begin
                        push_req.unit0 = SURR_HIGH_BASE | {6'd0, offset[19:10]};
                        push_req.unit1 = SURR_LOW_BASE | {6'd0, offset[9:0]};
                        push_req.pair  = 1'b1;
                    end
                end
                else
                begin
                    partial_next = acc;
                    left_next    = left_reg - 2'd1;
                end
            end
            else if (in_byte[7] == 1'b0)
            begin
                push_valid     = 1'b1;
                push_req.unit0 = {8'd0, in_byte};
            end
            else if ((in_byte[7:5] == 3'b110) && (in_byte[4:1] != 4'd0))
            begin
                partial_next = {16'd0, in_byte[4:0]};
                left_next    = SEQ_TWO;
                len_next     = SEQ_TWO;
            end
            else if (in_byte[7:4] == 4'b1110)
            begin
                partial_next = {17'd0, in_byte[3:0]};
                left_next    = SEQ_THREE;
                len_next     = SEQ_THREE;
            end
            else if (in_byte[7:3] == 5'b11110)
            begin
                partial_next = {18'd0, in_byte[2:0]};
                left_next    = SEQ_FOUR;
                len_next     = SEQ_FOUR;
            end
            else
            begin
                // bad or overlong lead
                push_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            left_reg    <= SEQ_NONE;
            len_reg     <= SEQ_NONE;
        end
        else
        begin
            partial_reg <= partial_next;
            left_reg    <= left_next;
            len_reg     <= len_next;
        end
    end

endmodule

// ===== hdl/u8u16_queue.sv =====
// Short request queue between the front and back ends.
module u8u16_queue
    import u8u16_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  unit_req_t push_req,
    output logic      pop_valid,
    input  logic      pop_ready,
    output unit_req_t pop_req
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    unit_req_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic do_push;
    logic do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_req    = slot_reg[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/u8u16_back.sv =====
// Back end: emits the queued code units one per cycle through an output register while out_ready keeps up.
module u8u16_back
    import u8u16_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        swap,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  unit_req_t   pop_req,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] code_unit,
    output logic        last_of_run
);

    logic        valid_reg, valid_next;
    logic        second_reg, second_next;
    logic [15:0] unit_reg, unit_next;
    logic        last_reg, last_next;
    logic [15:0] held_reg, held_next;

    logic        load;
    logic [15:0] pick;

    assign load      = !valid_reg || out_ready;
    assign pop_ready = load && !second_reg;

    always_comb
    begin
        valid_next  = valid_reg;
        second_next = second_reg;
        unit_next   = unit_reg;
        last_next   = last_reg;
        held_next   = held_reg;
        pick        = pop_req.unit0;
        if (load)
        begin
            if (second_reg)
            begin
                // second unit of a pair (low surrogate, or 0x0000 after 0xFFFD)
                valid_next  = 1'b1;
                second_next = 1'b0;
                pick        = held_reg;
                last_next   = 1'b1;
                unit_next   = swap ? {pick[7:0], pick[15:8]} : pick;
            end
            else if (pop_valid)
            begin
                valid_next  = 1'b1;
                second_next = pop_req.pair;
                held_next   = pop_req.unit1;
                pick        = pop_req.unit0;
                last_next   = !pop_req.pair;
                unit_next   = swap ? {pick[7:0], pick[15:8]} : pick;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unit_reg <= unit_next;
        last_reg <= last_next;
        held_reg <= held_next;
    end

    assign out_valid   = valid_reg;
    assign code_unit   = unit_reg;
    assign last_of_run = last_reg;

endmodule
